// File: design/graphics_rle_line_encoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the graphics run-length line encoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPHICS_RLE_LINE_ENCODER_DEFINES_SVH
`define GRAPHICS_RLE_LINE_ENCODER_DEFINES_SVH

// same-cycle implication
`define GRLE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grle assertion failed");

// next-cycle implication
`define GRLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grle assertion failed");

`endif

// File: design/grle_pkg.sv
// ----------------------------------------------------------------------------
// Graphics RLE line encoder package
// Shared types, code constants and the run-to-bytes encoder.
// ----------------------------------------------------------------------------
package grle_pkg;

	localparam int CFG_W       = 13;
	localparam int PIX_W       = 8;
	localparam int RUN_W       = 14;
	localparam int MAX_RESULTS = 10;
	localparam int BYTES_W     = MAX_RESULTS * 8;
	localparam int CNT_W       = 4;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST     = 13'd1920;
	localparam logic [CFG_W-1:0] PICTURE_HEIGHT_RST = 13'd1080;

	localparam logic [RUN_W-1:0] RUN_CAP   = 14'd16383;
	localparam logic [RUN_W-1:0] RUN_SHORT = 14'd63;
	localparam logic [RUN_W-1:0] RUN_LIT   = 14'd3;

	localparam logic [7:0] ESC_BYTE = 8'h00;
	localparam logic [1:0] MARK_ZERO_SHORT = 2'b00;
	localparam logic [1:0] MARK_ZERO_LONG  = 2'b01;
	localparam logic [1:0] MARK_COL_SHORT  = 2'b10;
	localparam logic [1:0] MARK_COL_LONG   = 2'b11;

	typedef enum logic [0:0] {
		REG_LINE_WIDTH     = 1'b0,
		REG_PICTURE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  n;
	} run_enc_t;

	typedef struct packed {
		logic [BYTES_W-1:0] data;
		logic [CNT_W-1:0]   cnt;
		logic               eol;
		logic               pd;
	} pack_t;

	// bytes beyond n are zero so packs can be merged with OR
	function automatic run_enc_t run_encode(logic [PIX_W-1:0] val, logic [RUN_W-1:0] len);
		run_enc_t r;
		r.bytes = '0;
		r.n     = '0;
		if (len != '0) begin
			if (val == '0) begin
				if (len <= RUN_SHORT) begin
					r.bytes = {16'h0, MARK_ZERO_SHORT, len[5:0], ESC_BYTE};
					r.n     = 3'd2;
				end else begin
					r.bytes = {8'h0, len[7:0], MARK_ZERO_LONG, len[13:8], ESC_BYTE};
					r.n     = 3'd3;
				end
			end else if (len <= RUN_LIT) begin
				unique case (len[1:0])
					2'd1: begin
						r.bytes = {24'h0, val};
						r.n     = 3'd1;
					end
					2'd2: begin
						r.bytes = {16'h0, val, val};
						r.n     = 3'd2;
					end
					default: begin
						r.bytes = {8'h0, val, val, val};
						r.n     = 3'd3;
					end
				endcase
			end else if (len <= RUN_SHORT) begin
				r.bytes = {8'h0, val, MARK_COL_SHORT, len[5:0], ESC_BYTE};
				r.n     = 3'd3;
			end else begin
				r.bytes = {val, len[7:0], MARK_COL_LONG, len[13:8], ESC_BYTE};
				r.n     = 3'd4;
			end
		end
		return r;
	endfunction

endpackage

// File: design/grle_ifs.sv
// ----------------------------------------------------------------------------
// Graphics RLE line encoder channels
// Valid/ready channels for the pixel input and the coded byte output.
// ----------------------------------------------------------------------------
interface grle_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;

	modport source (output valid, output pixel_index, input ready);
	modport sink   (input valid, input pixel_index, output ready);
endinterface

interface grle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_item;
	logic       line_done;
	logic       picture_done;

	modport source (output valid, output out_byte, output last_of_item,
		output line_done, output picture_done, input ready);
	modport sink   (input valid, input out_byte, input last_of_item,
		input line_done, input picture_done, output ready);
endinterface

// File: design/graphics_rle_line_encoder.sv
// ----------------------------------------------------------------------------
// Graphics run-length line encoder
// Palette-index pixels in raster order in, run-length coded byte stream out.
// ----------------------------------------------------------------------------
// A pixel that only extends an open run yields no bytes; one pixel per
// cycle is taken in that case while no earlier bytes wait at the output. A
// pixel that closes a run or a line yields one to ten bytes, and the byte
// output port, one byte per transaction, then holds the next pixel until the
// last of them is taken. The first byte of a pixel is offered from the
// serializer register after the pixel has passed the input stage register;
// a busy serializer can hold the pixel in between. The user must write line
// width and picture height only while the block is idle; the block does not
// enforce it. A value of zero acts as one, above MAX_DIMENSION as MAX_DIMENSION.
`include "graphics_rle_line_encoder_defines.svh"

module graphics_rle_line_encoder #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  grle_pkg::reg_idx_t         cfg_index,
	input  logic [grle_pkg::CFG_W-1:0] cfg_wdata,
	grle_pix_if.sink                   pix,
	grle_byte_if.source                bytes
);
	import grle_pkg::*;

	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] picture_height_q;
	logic             free;
	logic             pk_valid;
	pack_t            pk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q     <= LINE_WIDTH_RST;
			picture_height_q <= PICTURE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:     line_width_q     <= cfg_wdata;
				REG_PICTURE_HEIGHT: picture_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	grle_pack #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_pack (
		.clk            (clk),
		.arst_n         (arst_n),
		.line_width     (line_width_q),
		.picture_height (picture_height_q),
		.pix            (pix),
		.free           (free),
		.pk_valid       (pk_valid),
		.pk             (pk)
	);

	grle_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.pk_valid (pk_valid),
		.pk       (pk),
		.free     (free),
		.bytes    (bytes)
	);

	`GRLE_ASSERT_IMPL(a_eol_last, bytes.valid && bytes.line_done, bytes.last_of_item && bytes.out_byte == ESC_BYTE)
	`GRLE_ASSERT_IMPL(a_pic_eol, bytes.valid && bytes.picture_done, bytes.line_done)
	`GRLE_ASSERT_NEXT(a_item_cont, bytes.valid && bytes.ready && !bytes.last_of_item, bytes.valid)
	`GRLE_ASSERT_IMPL(a_load_free, pk_valid, !bytes.valid || (bytes.ready && bytes.last_of_item))

endmodule

// File: design/grle_pack.sv
// ----------------------------------------------------------------------------
// Graphics RLE run tracker and byte packer
// Holds the open run and raster position, turns each pixel into a byte pack.
// ----------------------------------------------------------------------------
module grle_pack #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [grle_pkg::CFG_W-1:0]    line_width,
	input  logic [grle_pkg::CFG_W-1:0]    picture_height,
	grle_pix_if.sink                      pix,
	input  logic                          free,
	output logic                          pk_valid,
	output grle_pkg::pack_t               pk
);
	import grle_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int SZ_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int POS_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
	localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_DIMENSION);

	logic             vld_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             take;

	logic [PIX_W-1:0] run_val_q;
	logic [RUN_W-1:0] run_cnt_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	logic [SZ_W-1:0]  w_eff;
	logic [SZ_W-1:0]  h_eff;
	logic [SZ_W-1:0]  lw_ext;
	logic [SZ_W-1:0]  ph_ext;
	logic [SZ_W-1:0]  col_nxt;
	logic [SZ_W-1:0]  row_nxt;
	logic             col_end;
	logic             last_line;
	logic             flush_old;
	logic [PIX_W-1:0] val_nxt;
	logic [RUN_W-1:0] cnt_nxt;
	run_enc_t         enc_a;
	run_enc_t         enc_b;

	assign take      = vld_s1 && free;
	assign pix.ready = !vld_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix.ready) begin
			vld_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pix_s1 <= pix.pixel_index;
		end
	end

	always_comb begin
		lw_ext = SZ_W'(line_width);
		ph_ext = SZ_W'(picture_height);
		if (lw_ext == '0) begin
			w_eff = SZ_W'(1);
		end else if (lw_ext > MAX_SZ) begin
			w_eff = MAX_SZ;
		end else begin
			w_eff = lw_ext;
		end
		if (ph_ext == '0) begin
			h_eff = SZ_W'(1);
		end else if (ph_ext > MAX_SZ) begin
			h_eff = MAX_SZ;
		end else begin
			h_eff = ph_ext;
		end
	end

	always_comb begin
		col_nxt   = SZ_W'(col_q) + SZ_W'(1);
		row_nxt   = SZ_W'(row_q) + SZ_W'(1);
		col_end   = col_nxt >= w_eff;
		last_line = row_nxt >= h_eff;

		flush_old = (run_cnt_q != '0) && ((pix_s1 != run_val_q) || (run_cnt_q >= RUN_CAP));
		enc_a     = flush_old ? run_encode(run_val_q, run_cnt_q) : '0;
		if (flush_old || run_cnt_q == '0) begin
			val_nxt = pix_s1;
			cnt_nxt = RUN_W'(1);
		end else begin
			val_nxt = run_val_q;
			cnt_nxt = run_cnt_q + RUN_W'(1);
		end
		enc_b = col_end ? run_encode(val_nxt, cnt_nxt) : '0;

		pk.data = BYTES_W'(enc_a.bytes) | (BYTES_W'(enc_b.bytes) << {enc_a.n, 3'b000});
		pk.cnt  = CNT_W'(enc_a.n) + CNT_W'(enc_b.n) + (col_end ? CNT_W'(2) : CNT_W'(0));
		pk.eol  = col_end;
		pk.pd   = col_end && last_line;
		pk_valid = take && (pk.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_val_q <= '0;
			run_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (take) begin
			run_val_q <= val_nxt;
			if (col_end) begin
				run_cnt_q <= '0;
				col_q     <= '0;
				row_q     <= last_line ? '0 : POS_W'(row_nxt);
			end else begin
				run_cnt_q <= cnt_nxt;
				col_q     <= POS_W'(col_nxt);
			end
		end
	end

endmodule

// File: design/grle_ser.sv
// ----------------------------------------------------------------------------
// Graphics RLE byte serializer
// Holds one byte pack and shifts it out one byte per transaction.
// ----------------------------------------------------------------------------
module grle_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pk_valid,
	input  grle_pkg::pack_t pk,
	output logic            free,
	grle_byte_if.source     bytes
);
	import grle_pkg::*;

	logic [BYTES_W-1:0] data_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               eol_q;
	logic               pd_q;
	logic               last;

	assign last  = cnt_q == CNT_W'(1);
	assign free  = (cnt_q == '0) || (last && bytes.ready);

	assign bytes.valid        = cnt_q != '0;
	assign bytes.out_byte     = data_q[7:0];
	assign bytes.last_of_item = last;
	assign bytes.line_done    = eol_q && last;
	assign bytes.picture_done = pd_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pk_valid) begin
			cnt_q <= pk.cnt;
		end else if (bytes.valid && bytes.ready) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pk_valid) begin
			data_q <= pk.data;
			eol_q  <= pk.eol;
			pd_q   <= pk.pd;
		end else if (bytes.valid && bytes.ready) begin
			data_q <= data_q >> 8;
		end
	end

endmodule
